// ----- rtl/lamp_color_report_decoder_core_assert.svh -----
// Assertion macros shared by the lamp color report decoder RTL.
`ifndef LAMP_COLOR_REPORT_DECODER_CORE_ASSERT_SVH
`define LAMP_COLOR_REPORT_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define LCRD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcrd: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define LCRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcrd: next-cycle check failed");

`endif

// ----- rtl/lcrd_pkg.sv -----
// Shared types and constants of the lamp color report decoder.
`default_nettype none

package lcrd_pkg;

  // Field and datapath widths
  localparam int BYTE_W     = 8;
  localparam int LVL_W      = 7;
  localparam int DVD_W      = 15;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_USED_W = 57;
  localparam int OUT_DATA_W = 64;
  localparam int ADDR_W     = 4;
  localparam int PDATA_W    = 32;

  // Arithmetic constants
  localparam logic [BYTE_W-1:0] REMOTE_LEVEL = 8'hFF;
  localparam logic [BYTE_W-1:0] DARK_COLOR   = 8'd128;
  localparam int                PCT_FULL     = 100;
  localparam int                RATIO_HALF   = 50;

  // Register reset values
  localparam logic [BYTE_W-1:0] LAYERED_RST    = 8'd2;
  localparam logic [BYTE_W-1:0] WC_ONLY_RST    = 8'd0;
  localparam logic [BYTE_W-1:0] TYPE_COUNT_RST = 8'd4;

  // Register index (word address)
  typedef enum logic [1:0] {
    REG_LAYERED    = 2'd0,
    REG_WC_ONLY    = 2'd1,
    REG_TYPE_COUNT = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  // Divisions run per remote-mode item, in this order
  typedef enum logic [2:0] {
    OP_RED   = 3'd0,
    OP_GREEN = 3'd1,
    OP_BLUE  = 3'd2,
    OP_WC    = 3'd3,
    OP_BG    = 3'd4
  } div_op_t;

  typedef struct packed {
    logic    load;
    logic    prep;
    logic    div_start;
    logic    store;
    logic    out_load;
    div_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic remote;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] layered_code;
    logic [BYTE_W-1:0] wc_only_code;
    logic [BYTE_W-1:0] type_count;
  } lcrd_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/lcrd_div.sv -----
// Shared restoring divider, two quotient bits per cycle, saturating at 255.
`default_nettype none

module lcrd_div
  import lcrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [BYTE_W-1:0] divisor,
  output logic              done,
  output logic [BYTE_W-1:0] quotient
);

  localparam int STEPS = BYTE_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] rem;
  logic [DVD_W-1:0] dsh;
  logic             sat;
  logic             hi_ge;
  logic             lo_ge;
  logic [DVD_W-1:0] rem_a;
  logic [DVD_W-1:0] rem_b;
  logic [DVD_W-1:0] dlo;

  // Quotient would not fit in a byte
  assign sat = {1'b0, dividend} >= {divisor, {BYTE_W{1'b0}}};

  // Two compare/subtract steps per cycle
  always_comb begin
    hi_ge = rem >= dsh;
    rem_a = hi_ge ? rem - dsh : rem;
    dlo   = dsh >> 1;
    lo_ge = rem_a >= dlo;
    rem_b = lo_ge ? rem_a - dlo : rem_a;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (sat) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= DVD_W'(divisor) << (DVD_W - BYTE_W);
      cnt      <= CNT_W'(STEPS - 1);
      quotient <= sat ? {BYTE_W{1'b1}} : '0;
    end else if (busy) begin
      rem      <= rem_b;
      dsh      <= dsh >> 2;
      cnt      <= cnt - CNT_W'(1);
      quotient <= {quotient[BYTE_W-3:0], hi_ge, lo_ge};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lcrd_dp.sv -----
// Datapath: item capture, operand select, divider, result assembly, output register.
`default_nettype none

module lcrd_dp
  import lcrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  input  lcrd_cfg_t             cfg,
  input  logic [IN_DATA_W-1:0]  in_data,
  output dp_stat_t              stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int N_W = DVD_W + 1;

  // Captured item
  logic [BYTE_W-1:0] dr, dg, db, dw, dc, sr, sg, sb, sl, sc, sw, hw;

  // Intermediate results
  logic [LVL_W-1:0]  lvl_q;
  logic [BYTE_W-1:0] q_r, q_g, q_b;
  logic [LVL_W-1:0]  wc_q, bg_q;
  logic [BYTE_W-1:0] lamp_kind;

  // Combinational
  logic [BYTE_W-1:0] mx, mn;
  logic [BYTE_W:0]   mm_sum;
  logic [N_W-1:0]    mm_prod;
  logic [BYTE_W-1:0] lvl_raw;
  logic [BYTE_W-1:0] lvl_dvs;
  logic              wc_gt, bg_gt;
  logic [DVD_W-1:0]  div_dvd;
  logic [BYTE_W-1:0] div_dvs;
  logic              div_done;
  logic [BYTE_W-1:0] div_q;
  logic [LVL_W-1:0]  wc_level, bg_level, wc_ratio, bg_ratio;
  logic [BYTE_W-1:0] r_o, g_o, b_o, l_o, cold_o, white_o, kind_next;
  logic              rgb_o;

  function automatic logic [DVD_W-1:0] times_const(input logic [BYTE_W-1:0] v,
                                                   input int k);
    return DVD_W'(v) * DVD_W'(k);
  endfunction

  // Level of a drive pair: max * 100 / 255, floored at 1 for nonzero drive
  function automatic logic [LVL_W-1:0] pair_level(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] x;
    logic [N_W-1:0]    n;
    logic [N_W-1:0]    q;
    x = (a > b) ? a : b;
    n = N_W'(x) * N_W'(PCT_FULL);
    q = (n + N_W'(1) + (n >> BYTE_W)) >> BYTE_W;
    if (q == '0 && x != '0) begin
      q = N_W'(1);
    end
    return q[LVL_W-1:0];
  endfunction

  // Capture and per-item intermediates
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dr <= in_data[0*BYTE_W +: BYTE_W];
      dg <= in_data[1*BYTE_W +: BYTE_W];
      db <= in_data[2*BYTE_W +: BYTE_W];
      dw <= in_data[3*BYTE_W +: BYTE_W];
      dc <= in_data[4*BYTE_W +: BYTE_W];
      sr <= in_data[5*BYTE_W +: BYTE_W];
      sg <= in_data[6*BYTE_W +: BYTE_W];
      sb <= in_data[7*BYTE_W +: BYTE_W];
      sl <= in_data[8*BYTE_W +: BYTE_W];
      sc <= in_data[9*BYTE_W +: BYTE_W];
      sw <= in_data[10*BYTE_W +: BYTE_W];
      hw <= in_data[11*BYTE_W +: BYTE_W];
    end
    if (cmd.prep) begin
      lvl_q <= (lvl_raw > BYTE_W'(PCT_FULL)) ? LVL_W'(PCT_FULL) : lvl_raw[LVL_W-1:0];
    end
    if (cmd.store) begin
      unique case (cmd.op)
        OP_RED:   q_r  <= div_q;
        OP_GREEN: q_g  <= div_q;
        OP_BLUE:  q_b  <= div_q;
        OP_WC:    wc_q <= div_q[LVL_W-1:0];
        OP_BG:    bg_q <= div_q[LVL_W-1:0];
        default:  ;
      endcase
    end
  end

  // Max/min lightness level
  always_comb begin
    mx = dr;
    mn = dr;
    if (dg > mx) mx = dg;
    if (db > mx) mx = db;
    if (dg < mn) mn = dg;
    if (db < mn) mn = db;
    mm_sum  = {1'b0, mx} + {1'b0, mn};
    mm_prod = N_W'(mm_sum) * N_W'(PCT_FULL);
    lvl_raw = mm_prod[N_W-1:BYTE_W];
  end

  // Divider operand select
  assign lvl_dvs = (lvl_q == '0) ? BYTE_W'(1) : BYTE_W'(lvl_q);
  assign wc_gt   = dw > dc;
  assign bg_gt   = db > dg;

  always_comb begin
    unique case (cmd.op)
      OP_RED: begin
        div_dvd = times_const(dr, PCT_FULL);
        div_dvs = lvl_dvs;
      end
      OP_GREEN: begin
        div_dvd = times_const(dg, PCT_FULL);
        div_dvs = lvl_dvs;
      end
      OP_BLUE: begin
        div_dvd = times_const(db, PCT_FULL);
        div_dvs = lvl_dvs;
      end
      OP_WC: begin
        div_dvd = wc_gt ? times_const(dc, RATIO_HALF) : times_const(dw, RATIO_HALF);
        div_dvs = wc_gt ? dw : ((dc == '0) ? BYTE_W'(1) : dc);
      end
      OP_BG: begin
        div_dvd = bg_gt ? times_const(dg, RATIO_HALF) : times_const(db, RATIO_HALF);
        div_dvs = bg_gt ? db : ((dg == '0) ? BYTE_W'(1) : dg);
      end
      default: begin
        div_dvd = '0;
        div_dvs = BYTE_W'(1);
      end
    endcase
  end

  lcrd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Pair levels and ratios
  always_comb begin
    wc_level = pair_level(dw, dc);
    bg_level = pair_level(db, dg);
    wc_ratio = wc_gt ? wc_q :
               ((dc != '0) ? LVL_W'(PCT_FULL) - wc_q : LVL_W'(RATIO_HALF));
    bg_ratio = bg_gt ? bg_q :
               ((dg != '0) ? LVL_W'(PCT_FULL) - bg_q : LVL_W'(RATIO_HALF));
  end

  // Result assembly
  always_comb begin
    kind_next = (hw >= cfg.type_count) ? cfg.wc_only_code : hw;
    rgb_o     = kind_next != cfg.wc_only_code;
    if (sl == REMOTE_LEVEL) begin
      if (lvl_q == '0) begin
        r_o = DARK_COLOR;
        g_o = DARK_COLOR;
        b_o = DARK_COLOR;
        l_o = BYTE_W'(|{dr, dg, db});
      end else begin
        r_o = q_r;
        g_o = q_g;
        b_o = q_b;
        l_o = BYTE_W'(lvl_q);
      end
      // Layered lamp: blue/green becomes level and ratio
      if (lamp_kind == cfg.layered_code) begin
        r_o = sr;
        l_o = BYTE_W'(bg_level);
        b_o = BYTE_W'(bg_ratio);
      end
      white_o = BYTE_W'(wc_level);
      cold_o  = BYTE_W'(wc_ratio);
    end else begin
      r_o     = sr;
      g_o     = sg;
      b_o     = sb;
      l_o     = sl;
      cold_o  = sc;
      white_o = sw;
    end
  end

  // Output register and lamp type state
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      lamp_kind <= '0;
    end else if (cmd.out_load) begin
      m_tvalid  <= 1'b1;
      lamp_kind <= kind_next;
    end else if (m_tready) begin
      m_tvalid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {{(OUT_DATA_W - OUT_USED_W){1'b0}}, rgb_o, kind_next,
                  white_o, cold_o, l_o, b_o, g_o, r_o};
    end
  end

  // Status
  assign stat.remote   = sl == REMOTE_LEVEL;
  assign stat.div_done = div_done;
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

`default_nettype wire

// ----- rtl/lcrd_ctrl.sv -----
// Controller: sequences capture, level prep, the five divisions (remote mode only) and the result load.
`default_nettype none

module lcrd_ctrl
  import lcrd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_accept,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     idle
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_START  = 5'b00100,
    S_WAIT   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t  state, state_next;
  div_op_t op, op_next, op_succ;

  // Division order
  always_comb begin
    unique case (op)
      OP_RED:   op_succ = OP_GREEN;
      OP_GREEN: op_succ = OP_BLUE;
      OP_BLUE:  op_succ = OP_WC;
      OP_WC:    op_succ = OP_BG;
      default:  op_succ = OP_BG;
    endcase
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    idle       = 1'b0;
    unique case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (in_accept) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        op_next    = OP_RED;
        state_next = stat.remote ? S_START : S_FINISH;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (stat.div_done) begin
          cmd.store = 1'b1;
          if (op == OP_BG) begin
            state_next = S_FINISH;
          end else begin
            op_next    = op_succ;
            state_next = S_START;
          end
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_RED;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lamp_color_report_decoder_core.sv -----
// Top level of the lamp color report decoder: stream ports, register port, core.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+---------------------------------
//  s_*     | in  | s_tvalid / s_tready       | s_tdata: one lamp status report
//  m_*     | out | m_tvalid / m_tready       | m_tdata: one decoded result
//  apb     | in  | psel, penable, pwrite     | paddr / pwdata / prdata
//
// A report with set_level != 255 skips the divider: capture, level prep, result load.
// In remote mode the shared divider runs five divisions in turn; one whose quotient
// saturates ends without running the bit loop, and the result load follows the last.
// A new report is taken once the previous result sits in the output register.
// rst is synchronous; it clears the controller, divider and output valid, and
// loads the register reset values. m_tready low holds the result in place.
`default_nettype none
`include "lamp_color_report_decoder_core_assert.svh"

module lamp_color_report_decoder_core
  import lcrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // drive_red, drive_green, drive_blue, drive_warm, drive_cool, set_red,
  // set_green, set_blue, set_level, set_cold_ratio, set_white_level,
  // hw_config (8 bits each, lowest first)
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // Output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // red_out, green_out, blue_out, level_out, cold_out, white_out,
  // lamp_type_out (8 bits each), rgb_supported (1 bit), zero pad to 64
  output logic [OUT_DATA_W-1:0] m_tdata,
  // Register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  lcrd_cfg_t cfg;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic      in_accept;
  logic      cfg_write;
  reg_idx_t  reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign in_accept = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layered_code <= LAYERED_RST;
      cfg.wc_only_code <= WC_ONLY_RST;
      cfg.type_count   <= TYPE_COUNT_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_LAYERED:    cfg.layered_code <= pwdata[BYTE_W-1:0];
        REG_WC_ONLY:    cfg.wc_only_code <= pwdata[BYTE_W-1:0];
        REG_TYPE_COUNT: cfg.type_count   <= pwdata[BYTE_W-1:0];
        REG_NONE:       ;
        default:        ;
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (reg_idx)
      REG_LAYERED:    prdata = PDATA_W'(cfg.layered_code);
      REG_WC_ONLY:    prdata = PDATA_W'(cfg.wc_only_code);
      REG_TYPE_COUNT: prdata = PDATA_W'(cfg.type_count);
      default:        prdata = '0;
    endcase
  end

  lcrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .stat      (stat),
    .cmd       (cmd),
    .idle      (s_tready)
  );

  lcrd_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (s_tdata),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Checks
  `LCRD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `LCRD_ASSERT_NOW(a_store_on_done, cmd.store, stat.div_done)
  `LCRD_ASSERT_NOW(a_load_into_free_slot, cmd.out_load, stat.out_free)

endmodule

`default_nettype wire

// ----- verif/lamp_color_report_decoder_core_tb.sv -----
// Self-checking testbench for lamp_color_report_decoder_core: stream traffic with a predictor.
`timescale 1ns / 100ps

module lamp_color_report_decoder_core_tb
  import lcrd_pkg::*;
();

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 182;

  // One status report, first field in the lowest bits
  typedef struct packed {
    logic [7:0] hw_config;
    logic [7:0] set_white_level;
    logic [7:0] set_cold_ratio;
    logic [7:0] set_level;
    logic [7:0] set_blue;
    logic [7:0] set_green;
    logic [7:0] set_red;
    logic [7:0] drive_cool;
    logic [7:0] drive_warm;
    logic [7:0] drive_blue;
    logic [7:0] drive_green;
    logic [7:0] drive_red;
  } lamp_report_t;

  // One decoded view, zero padded to 64 bits
  typedef struct packed {
    logic [6:0] pad;
    logic       rgb_supported;
    logic [7:0] lamp_type_out;
    logic [7:0] white_out;
    logic [7:0] cold_out;
    logic [7:0] level_out;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
  } lamp_view_t;

  // Predicts the user view of each report and matches results in order
  class lamp_view_tracker;
    logic [7:0]  layered_code = LAYERED_RST;
    logic [7:0]  wc_only_code = WC_ONLY_RST;
    logic [7:0]  type_count   = TYPE_COUNT_RST;
    logic [7:0]  kept_type    = 8'd0;
    lamp_view_t  views_due[$];
    int unsigned errors       = 0;

    function void set_reg(reg_idx_t idx, logic [7:0] val);
      case (idx)
        REG_LAYERED:    layered_code = val;
        REG_WC_ONLY:    wc_only_code = val;
        REG_TYPE_COUNT: type_count   = val;
        default: ;
      endcase
    endfunction

    // Drive pair to level percent plus ratio, 50 = balanced
    function void level_and_ratio(input int unsigned lo, input int unsigned hi,
                                  output int unsigned lv, output int unsigned rt);
      if (lo > hi) begin
        lv = lo * 100 / 255;
        rt = hi * 50 / lo;
      end else if (hi > 0) begin
        lv = hi * 100 / 255;
        rt = 100 - (lo * 50 / hi);
      end else begin
        lv = 0;
        rt = 50;
      end
      if (lv == 0 && (lo != 0 || hi != 0)) lv = 1;
      if (lv > 100) lv = 100;
      if (rt > 100) rt = 100;
    endfunction

    function logic [7:0] unscale_channel(int unsigned drive, int unsigned lvl);
      int unsigned t;
      t = drive * 100 / lvl;
      return (t > 255) ? 8'd255 : 8'(t);
    endfunction

    function lamp_view_t decode_report(lamp_report_t r);
      lamp_view_t  v;
      int unsigned mx, mn, lvl, lv, rt;
      v = '0;
      if (r.set_level == REMOTE_LEVEL) begin
        // Rebuild from drive bytes: lightness from max/min
        mx = r.drive_red;
        mn = r.drive_red;
        if (r.drive_green > mx) mx = r.drive_green;
        if (r.drive_blue > mx)  mx = r.drive_blue;
        if (r.drive_green < mn) mn = r.drive_green;
        if (r.drive_blue < mn)  mn = r.drive_blue;
        lvl = (mx + mn) * 100 / 256;
        if (lvl > 100) lvl = 100;
        if (lvl > 0) begin
          v.level_out = 8'(lvl);
          v.red_out   = unscale_channel(r.drive_red, lvl);
          v.green_out = unscale_channel(r.drive_green, lvl);
          v.blue_out  = unscale_channel(r.drive_blue, lvl);
        end else begin
          v.red_out   = DARK_COLOR;
          v.green_out = DARK_COLOR;
          v.blue_out  = DARK_COLOR;
          v.level_out = (r.drive_red != 0 || r.drive_green != 0 || r.drive_blue != 0)
                        ? 8'd1 : 8'd0;
        end
        // Layered lamp: blue/green becomes level plus ratio
        if (kept_type == layered_code) begin
          v.red_out = r.set_red;
          level_and_ratio(r.drive_blue, r.drive_green, lv, rt);
          v.level_out = 8'(lv);
          v.blue_out  = 8'(rt);
        end
        level_and_ratio(r.drive_warm, r.drive_cool, lv, rt);
        v.white_out = 8'(lv);
        v.cold_out  = 8'(rt);
      end else begin
        v.red_out   = r.set_red;
        v.green_out = r.set_green;
        v.blue_out  = r.set_blue;
        v.level_out = r.set_level;
        v.cold_out  = r.set_cold_ratio;
        v.white_out = r.set_white_level;
      end
      // Type range correction, kept for the next report
      kept_type = (r.hw_config >= type_count) ? wc_only_code : r.hw_config;
      v.lamp_type_out = kept_type;
      v.rgb_supported = (kept_type != wc_only_code);
      return v;
    endfunction

    function void take_report(lamp_report_t r);
      views_due.push_back(decode_report(r));
    endfunction

    function void check_field(string name, int unsigned expv, int unsigned got);
      if (expv != got) begin
        $error("%s: expected %0d, actual %0d", name, expv, got);
        errors++;
      end
    endfunction

    function void match_view(lamp_view_t got);
      lamp_view_t expv;
      if (views_due.size() == 0) begin
        $error("result item with no report pending");
        errors++;
        return;
      end
      expv = views_due.pop_front();
      check_field("red_out", expv.red_out, got.red_out);
      check_field("green_out", expv.green_out, got.green_out);
      check_field("blue_out", expv.blue_out, got.blue_out);
      check_field("level_out", expv.level_out, got.level_out);
      check_field("cold_out", expv.cold_out, got.cold_out);
      check_field("white_out", expv.white_out, got.white_out);
      check_field("lamp_type_out", expv.lamp_type_out, got.lamp_type_out);
      check_field("rgb_supported", expv.rgb_supported, got.rgb_supported);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // drive_red .. hw_config, 8 bits each, lowest first
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // red_out .. lamp_type_out, rgb_supported, pad
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]    pwdata;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  lamp_view_tracker tracker;
  bit               idle_on = 1'b1;
  int unsigned      cycles  = 0;

  lamp_color_report_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("lamp_color_report_decoder_core verification failed");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.match_view(lamp_view_t'(m_tdata));
  end

  // Receiver: ready in random runs, broken by random low bursts while idle_on is set
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(negedge clk);
      end
    end
  end

  // Present one report until taken, then maybe leave a gap
  task automatic send_report(lamp_report_t rpt);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= rpt;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_report(rpt);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9) - 1) @(negedge clk);
    end
  endtask

  // Register write: setup cycle, then access cycle
  task automatic write_reg(reg_idx_t idx, logic [7:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    tracker.set_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait for every pending view, then let the core settle
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.views_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic lamp_report_t report_of(
      logic [7:0] dr, logic [7:0] dg, logic [7:0] db, logic [7:0] dw, logic [7:0] dc,
      logic [7:0] sr, logic [7:0] sg, logic [7:0] sb, logic [7:0] sl, logic [7:0] sc,
      logic [7:0] sw, logic [7:0] hw);
    lamp_report_t r;
    r.drive_red       = dr;
    r.drive_green     = dg;
    r.drive_blue      = db;
    r.drive_warm      = dw;
    r.drive_cool      = dc;
    r.set_red         = sr;
    r.set_green       = sg;
    r.set_blue        = sb;
    r.set_level       = sl;
    r.set_cold_ratio  = sc;
    r.set_white_level = sw;
    r.hw_config       = hw;
    return r;
  endfunction

  // Drive bytes biased toward zero, full scale and tiny values
  function automatic logic [7:0] rand_drive();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(1, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Type codes biased toward the layered code and the range edge
  function automatic logic [7:0] rand_type();
    case ($urandom_range(0, 5))
      0, 1:    return tracker.layered_code;
      2:       return tracker.type_count;
      3:       return tracker.type_count - 8'd1;
      4:       return 8'($urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic lamp_report_t rand_report();
    return report_of(rand_drive(), rand_drive(), rand_drive(), rand_drive(), rand_drive(),
                     8'($urandom), 8'($urandom), 8'($urandom),
                     ($urandom_range(0, 1) == 1) ? REMOTE_LEVEL : 8'($urandom),
                     8'($urandom), 8'($urandom), rand_type());
  endfunction

  // Register settings per phase: layered code, warm/cold-only code, type count
  logic [7:0] phase_cfg [PHASES][3] = '{
    '{8'd2,   8'd0,   8'd4},
    '{8'd0,   8'd255, 8'd1},
    '{8'd255, 8'd255, 8'd255},
    '{8'd7,   8'd7,   8'd0},
    '{8'd3,   8'd200, 8'd128},
    '{8'd2,   8'd0,   8'd4}
  };

  initial begin
    tracker  = new();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed reports under reset register values
    send_report(report_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_report(report_of(255, 255, 255, 255, 255, 255, 255, 255, 254, 255, 255, 255));
    // remote, all drives dark; leaves a layered type behind
    send_report(report_of(0, 0, 0, 0, 0, 9, 8, 7, REMOTE_LEVEL, 1, 2, 2));
    // layered, tiny blue and warm/cold drives
    send_report(report_of(1, 0, 1, 1, 2, 200, 100, 50, REMOTE_LEVEL, 0, 0, 2));
    send_report(report_of(0, 0, 255, 255, 0, 17, 0, 0, REMOTE_LEVEL, 0, 0, 1));
    // plain color with channel overflow
    send_report(report_of(255, 0, 0, 0, 255, 0, 0, 0, REMOTE_LEVEL, 0, 0, 3));
    // full drives, level clamp; type out of range
    send_report(report_of(255, 255, 255, 255, 255, 3, 3, 3, REMOTE_LEVEL, 3, 3, 4));
    // dark but nonzero color
    send_report(report_of(2, 0, 0, 1, 0, 5, 6, 7, REMOTE_LEVEL, 8, 9, 3));
    // smallest nonzero level, channel saturates
    send_report(report_of(3, 0, 0, 0, 3, 1, 1, 1, REMOTE_LEVEL, 1, 1, 2));
    send_report(report_of(0, 255, 0, 128, 64, 44, 55, 66, REMOTE_LEVEL, 77, 88, 1));
    send_report(report_of(10, 20, 30, 40, 40, 1, 2, 3, 100, 50, 50, 2));
    send_report(report_of(100, 200, 50, 7, 200, 90, 91, 92, REMOTE_LEVEL, 93, 94, 0));
    send_report(report_of(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
                          8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
    send_report(report_of(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
                          8'hAA, 8'h55, REMOTE_LEVEL, 8'h55, 8'hAA, 8'h55));

    // Random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        if (p == 1) write_reg(REG_NONE, 8'($urandom));
        write_reg(REG_LAYERED, phase_cfg[p][0]);
        write_reg(REG_WC_ONLY, phase_cfg[p][1]);
        write_reg(REG_TYPE_COUNT, phase_cfg[p][2]);
      end
      if (p == PHASES - 1) idle_on = 1'b0;
      repeat (PHASE_ITEMS) send_report(rand_report());
    end

    wait_drained();
    if (tracker.errors == 0 && tracker.views_due.size() == 0) begin
      $display("lamp_color_report_decoder_core verification clean");
    end else begin
      $display("lamp_color_report_decoder_core verification failed");
    end
    $finish;
  end

endmodule
